### hw/rtl/nbss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbss_pkg
// Shared types and constants for the NetBIOS session / SMB2 header parser.
// ----------------------------------------------------------------------------
package nbss_pkg;

  localparam int NBSS_LEN = 4;
  localparam int SMB2_LEN = 64;
  localparam int POS_W    = 7;

  localparam logic [POS_W-1:0] POS_TYPE    = POS_W'(0);
  localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LEN_MID = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_MAGIC   = POS_W'(NBSS_LEN);
  localparam logic [POS_W-1:0] POS_SIZE    = POS_W'(NBSS_LEN + 4);
  localparam logic [POS_W-1:0] POS_CHARGE  = POS_W'(NBSS_LEN + 6);
  localparam logic [POS_W-1:0] POS_STATUS  = POS_W'(NBSS_LEN + 8);
  localparam logic [POS_W-1:0] POS_COMMAND = POS_W'(NBSS_LEN + 12);
  localparam logic [POS_W-1:0] POS_FLAGS   = POS_W'(NBSS_LEN + 16);
  localparam logic [POS_W-1:0] POS_NEXT    = POS_W'(NBSS_LEN + 20);
  localparam logic [POS_W-1:0] POS_MSG     = POS_W'(NBSS_LEN + 24);
  localparam logic [POS_W-1:0] POS_TREE    = POS_W'(NBSS_LEN + 36);
  localparam logic [POS_W-1:0] POS_SESS    = POS_W'(NBSS_LEN + 40);
  localparam logic [POS_W-1:0] POS_LAST    = POS_W'(NBSS_LEN + SMB2_LEN - 1);
  localparam logic [POS_W-1:0] POS_END     = POS_W'(NBSS_LEN + SMB2_LEN);

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_BAD_MAGIC  = 2'd1;
  localparam logic [1:0] STATUS_OTHER_TYPE = 2'd2;

  typedef struct packed {
    logic [1:0]  parse_status;
    logic [7:0]  session_type;
    logic [16:0] session_length;
    logic [15:0] structure_size;
    logic [15:0] credit_charge;
    logic [31:0] nt_status;
    logic [15:0] smb_command;
    logic [31:0] header_flags;
    logic [31:0] next_command_offset;
    logic [63:0] message_id;
    logic [31:0] tree_id;
    logic [63:0] session_id;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'hfe;
      2'd1:    m = 8'h53;
      2'd2:    m = 8'h4d;
      default: m = 8'h42;
    endcase
    return m;
  endfunction

endpackage

### hw/rtl/nbss_parse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbss_parse_core
// Byte position tracker and field capture; flags a result on the byte that
// completes the header or ends the parse with an error.
// ----------------------------------------------------------------------------
module nbss_parse_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                flow_start,
  input  logic [7:0]          accepted_type,
  output logic                res_valid,
  output nbss_pkg::result_t   res
);

  logic [nbss_pkg::POS_W-1:0] pos_r, pos_nxt, pos_eff, rel;
  logic                       halted_r, halted_nxt, halt_eff, live;
  logic [7:0]                 type_r;
  logic [16:0]                len_r;
  logic [15:0]                size_r, charge_r, command_r;
  logic [31:0]                status_r, flags_r, next_r, tree_r;
  logic [63:0]                msg_r, sess_r;
  logic                       err_type, err_magic, done;

  // flow start restarts the parse on this very byte
  assign pos_eff  = flow_start ? nbss_pkg::POS_TYPE : pos_r;
  assign halt_eff = flow_start ? 1'b0 : halted_r;
  assign live     = accept && !halt_eff;

  assign err_type  = (pos_eff == nbss_pkg::POS_LEN_LO) && (type_r != accepted_type);
  assign err_magic = (pos_eff >= nbss_pkg::POS_MAGIC) && (pos_eff < nbss_pkg::POS_SIZE) &&
                     (data_byte != nbss_pkg::magic_byte(pos_eff[1:0]));
  assign done      = pos_eff >= nbss_pkg::POS_LAST;

  assign res_valid = live && (err_type || err_magic || done);

  always_comb begin
    res = '0;
    res.session_type   = type_r;
    res.session_length = (pos_eff == nbss_pkg::POS_LEN_LO) ? {len_r[16:8], data_byte} : len_r;
    if (err_type) begin
      res.parse_status = nbss_pkg::STATUS_OTHER_TYPE;
    end else if (err_magic) begin
      res.parse_status = nbss_pkg::STATUS_BAD_MAGIC;
    end else begin
      res.parse_status        = nbss_pkg::STATUS_OK;
      res.structure_size      = size_r;
      res.credit_charge       = charge_r;
      res.nt_status           = status_r;
      res.smb_command         = command_r;
      res.header_flags        = flags_r;
      res.next_command_offset = next_r;
      res.message_id          = msg_r;
      res.tree_id             = tree_r;
      res.session_id          = sess_r;
    end
  end

  always_comb begin
    pos_nxt    = pos_eff;
    halted_nxt = halt_eff;
    if (accept) begin
      if (live) begin
        if (pos_eff < nbss_pkg::POS_END) begin
          pos_nxt = pos_eff + 1'b1;
        end
        if (err_type || err_magic || done) begin
          halted_nxt = 1'b1;
        end
      end
    end else begin
      pos_nxt    = pos_r;
      halted_nxt = halted_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= nbss_pkg::POS_TYPE;
      halted_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      halted_r <= halted_nxt;
    end
  end

  // header fields, one byte lane per word
  always_ff @(posedge clk) begin
    if (live) begin
      if (pos_eff == nbss_pkg::POS_TYPE) begin
        type_r <= data_byte;
      end
      if (pos_eff == nbss_pkg::POS_LEN_HI) begin
        len_r <= {data_byte[0], 16'h0000};
      end
      if (pos_eff == nbss_pkg::POS_LEN_MID) begin
        len_r[15:8] <= data_byte;
      end
      if (pos_eff == nbss_pkg::POS_LEN_LO) begin
        len_r[7:0] <= data_byte;
      end
      if (pos_eff >= nbss_pkg::POS_SIZE && pos_eff < nbss_pkg::POS_CHARGE) begin
        size_r[{rel[0], 3'b000} +: 8] <= data_byte;
      end
      if (pos_eff >= nbss_pkg::POS_CHARGE && pos_eff < nbss_pkg::POS_STATUS) begin
        charge_r[{rel[0], 3'b000} +: 8] <= data_byte;
      end
      if (pos_eff >= nbss_pkg::POS_STATUS && pos_eff < nbss_pkg::POS_COMMAND) begin
        status_r[{rel[1:0], 3'b000} +: 8] <= data_byte;
      end
      if (pos_eff >= nbss_pkg::POS_COMMAND && pos_eff < nbss_pkg::POS_COMMAND + 2) begin
        command_r[{rel[0], 3'b000} +: 8] <= data_byte;
      end
      if (pos_eff >= nbss_pkg::POS_FLAGS && pos_eff < nbss_pkg::POS_NEXT) begin
        flags_r[{rel[1:0], 3'b000} +: 8] <= data_byte;
      end
      if (pos_eff >= nbss_pkg::POS_NEXT && pos_eff < nbss_pkg::POS_MSG) begin
        next_r[{rel[1:0], 3'b000} +: 8] <= data_byte;
      end
      if (pos_eff >= nbss_pkg::POS_MSG && pos_eff < nbss_pkg::POS_MSG + 8) begin
        msg_r[{rel[2:0], 3'b000} +: 8] <= data_byte;
      end
      if (pos_eff >= nbss_pkg::POS_TREE && pos_eff < nbss_pkg::POS_SESS) begin
        tree_r[{rel[1:0], 3'b000} +: 8] <= data_byte;
      end
      if (pos_eff >= nbss_pkg::POS_SESS && pos_eff < nbss_pkg::POS_SESS + 8) begin
        sess_r[{rel[2:0], 3'b000} +: 8] <= data_byte;
      end
    end
  end

  // lane offset inside the field that the position falls in
  always_comb begin
    if (pos_eff >= nbss_pkg::POS_SESS) begin
      rel = pos_eff - nbss_pkg::POS_SESS;
    end else if (pos_eff >= nbss_pkg::POS_TREE) begin
      rel = pos_eff - nbss_pkg::POS_TREE;
    end else if (pos_eff >= nbss_pkg::POS_MSG) begin
      rel = pos_eff - nbss_pkg::POS_MSG;
    end else begin
      rel = pos_eff;  // aligned fields below use the low bits directly
    end
  end

endmodule

### hw/rtl/nbss_smb2_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbss_smb2_header_parser
// NetBIOS session header and SMB2 header parser, one byte per word.
// ----------------------------------------------------------------------------
// a result is registered into the output register, or into the skid entry while the output is held
// throughput: one byte per cycle while in_stall is low, set by the registered position update
// a two-entry output buffer lets bytes flow while a result waits
// synchronous active-low reset clears position, halt flag, buffer valids and
// the accepted session type; the first byte after reset is the session type
module nbss_smb2_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_flow_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_parse_status,
  output logic [7:0]  out_session_type,
  output logic [16:0] out_session_length,
  output logic [15:0] out_structure_size,
  output logic [15:0] out_credit_charge,
  output logic [31:0] out_nt_status,
  output logic [15:0] out_smb_command,
  output logic [31:0] out_header_flags,
  output logic [31:0] out_next_command_offset,
  output logic [63:0] out_message_id,
  output logic [31:0] out_tree_id,
  output logic [63:0] out_session_id,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic              accept, push, pop;
  logic [7:0]        acc_type_r;
  logic              res_valid;
  nbss_pkg::result_t res;
  nbss_pkg::result_t out_r, skid_r;
  logic              out_valid_r, skid_valid_r;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && res_valid;
  assign pop      = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_type_r <= 8'h00;
    end else if (cfg_wr_en) begin
      acc_type_r <= cfg_wr_data;
    end
  end

  nbss_parse_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_data_byte),
    .flow_start    (in_flow_start),
    .accepted_type (acc_type_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (push) begin
        out_r <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_parse_status        = out_r.parse_status;
  assign out_session_type        = out_r.session_type;
  assign out_session_length      = out_r.session_length;
  assign out_structure_size      = out_r.structure_size;
  assign out_credit_charge       = out_r.credit_charge;
  assign out_nt_status           = out_r.nt_status;
  assign out_smb_command         = out_r.smb_command;
  assign out_header_flags        = out_r.header_flags;
  assign out_next_command_offset = out_r.next_command_offset;
  assign out_message_id          = out_r.message_id;
  assign out_tree_id             = out_r.tree_id;
  assign out_session_id          = out_r.session_id;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid_r)
    else $error("pushed result not presented");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.parse_status != nbss_pkg::STATUS_OK) |->
      (out_r.message_id == 64'd0 && out_r.session_id == 64'd0 &&
       out_r.structure_size == 16'd0))
    else $error("error result carries header fields");

endmodule
